/* rtl/srtf_pkg.sv */
// ----------------------------------------------------------------------------
// srtf_pkg
// shared types and constants for the shortest-remaining-time-first scheduler
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int MAX_JOBS_DEF = 16;

    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [7:0]  process_id;
        logic [15:0] arrival_time;
        logic [11:0] burst_time;
    } cmd_t;

    typedef struct packed {
        logic [15:0] time_now;
        logic        running_valid;
        logic [7:0]  running_pid;
        logic        new_segment;
        logic        finished;
        logic [15:0] finish_time;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        all_done;
    } rpt_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [11:0] burst;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESTART,
        ST_SCAN,
        ST_RUN,
        ST_TAT,
        ST_WAIT,
        ST_OUT
    } state_t;

endpackage

/* rtl/srtf_table.sv */
// ----------------------------------------------------------------------------
// srtf_table
// job slot storage: id, arrival and burst memory plus remaining-time memory
// ----------------------------------------------------------------------------
module srtf_table #(
    parameter int MAX_JOBS = srtf_pkg::MAX_JOBS_DEF,
    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ld_en,
    input  logic [IDX_W-1:0]     ld_addr,
    input  srtf_pkg::entry_t     ld_entry,
    input  logic                 rem_we,
    input  logic [IDX_W-1:0]     rem_addr,
    input  logic [11:0]          rem_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output srtf_pkg::entry_t     rd_entry,
    output logic [11:0]          rd_rem
);

    srtf_pkg::entry_t  entry_mem [MAX_JOBS];
    logic [11:0]       rem_mem   [MAX_JOBS];
    logic [MAX_JOBS-1:0] rem_vld_reg;
    logic [11:0]       rem_q_reg;
    logic              rem_vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (ld_en)
        begin
            entry_mem[ld_addr] <= ld_entry;
        end
        if (rem_we)
        begin
            rem_mem[rem_addr] <= rem_data;
        end
        rd_entry  <= entry_mem[rd_addr];
        rem_q_reg <= rem_mem[rd_addr];
    end

    // remaining store resets to zero through per-entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_vld_reg   <= '0;
            rem_vld_q_reg <= 1'b0;
        end
        else
        begin
            if (rem_we)
            begin
                rem_vld_reg[rem_addr] <= 1'b1;
            end
            rem_vld_q_reg <= rem_vld_reg[rd_addr];
        end
    end

    assign rd_rem = rem_vld_q_reg ? rem_q_reg : 12'd0;

endmodule

/* rtl/srtf_scheduler.sv */
// ----------------------------------------------------------------------------
// srtf_scheduler
// preemptive shortest-remaining-time-first scheduler over a table of job slots
// ----------------------------------------------------------------------------
//  channel  | signals                      | role
//  ---------+------------------------------+---------------------------------
//  cmd      | cmd_valid, cmd_stall, cmd    | load, tick and restart items in
//  rpt      | rpt_valid, rpt_stall, rpt    | one report item out per tick
//  cfg      | cfg_wr_en, cfg_wr_data       | process count register write
//
//  load writes its slot on acceptance. restart copies one slot per cycle over
//  every slot. a tick scans the active slots through the single compare unit
//  and the one table read port, runs the pick, then reports turnaround/wait.
//  rst_n clears time, completion count, last slot and remaining times.
//  a report waiting under rpt_stall holds only the final hand-off of a tick.
// ----------------------------------------------------------------------------
module srtf_scheduler #(
    parameter int MAX_JOBS = srtf_pkg::MAX_JOBS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  srtf_pkg::cmd_t   cmd,
    output logic             rpt_valid,
    input  logic             rpt_stall,
    output srtf_pkg::rpt_t   rpt,
    input  logic             cfg_wr_en,
    input  logic [4:0]       cfg_wr_data
);

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

    srtf_pkg::state_t  state_reg, state_next;
    logic [4:0]        pc_reg;
    logic [15:0]       time_reg, time_next;
    logic [CNT_W-1:0]  done_cnt_reg, done_cnt_next;
    logic              last_valid_reg, last_valid_next;
    logic [IDX_W-1:0]  last_slot_reg, last_slot_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [11:0]       best_rem_reg, best_rem_next;
    srtf_pkg::entry_t  best_reg, best_next;
    srtf_pkg::rpt_t    res_reg, res_next;
    srtf_pkg::rpt_t    rpt_reg, rpt_next;
    logic              rpt_valid_reg, rpt_valid_next;

    logic              accept;
    logic [CNT_W-1:0]  active_n;
    logic [CNT_W-1:0]  scan_lim;
    logic              issue;
    logic              ld_en;
    logic              rem_we;
    logic [IDX_W-1:0]  rem_addr;
    logic [11:0]       rem_data;
    srtf_pkg::entry_t  rd_entry;
    logic [11:0]       rd_rem;
    srtf_pkg::entry_t  ld_entry;
    logic [15:0]       time_inc;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != srtf_pkg::ST_IDLE);
    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

    assign active_n = (CW'(pc_reg) > CW'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : CNT_W'(pc_reg);
    assign scan_lim = (state_reg == srtf_pkg::ST_SCAN) ? active_n : CNT_W'(MAX_JOBS);
    assign issue    = ((state_reg == srtf_pkg::ST_SCAN) || (state_reg == srtf_pkg::ST_RESTART))
                      && (idx_reg < scan_lim);
    assign time_inc = (time_reg < srtf_pkg::TIME_MAX) ? time_reg + 16'd1 : time_reg;

    assign ld_en = accept && (cmd.kind == srtf_pkg::KIND_LOAD) && (32'(cmd.slot) < MAX_JOBS);
    assign ld_entry.id      = cmd.process_id;
    assign ld_entry.arrival = cmd.arrival_time;
    assign ld_entry.burst   = cmd.burst_time;

    always_comb
    begin
        rem_we   = 1'b0;
        rem_addr = pend_idx_reg;
        rem_data = rd_entry.burst;
        if ((state_reg == srtf_pkg::ST_RESTART) && pend_reg)
        begin
            rem_we = 1'b1;
        end
        else if ((state_reg == srtf_pkg::ST_RUN) && found_reg)
        begin
            rem_we   = 1'b1;
            rem_addr = best_idx_reg;
            rem_data = best_rem_reg - 12'd1;
        end
    end

    srtf_table #(
        .MAX_JOBS (MAX_JOBS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld_en    (ld_en),
        .ld_addr  (IDX_W'(cmd.slot)),
        .ld_entry (ld_entry),
        .rem_we   (rem_we),
        .rem_addr (rem_addr),
        .rem_data (rem_data),
        .rd_addr  (idx_reg[IDX_W-1:0]),
        .rd_entry (rd_entry),
        .rd_rem   (rd_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srtf_pkg::ST_IDLE:
            begin
                if (accept && (cmd.kind == srtf_pkg::KIND_TICK))
                begin
                    state_next = srtf_pkg::ST_SCAN;
                end
                else if (accept && (cmd.kind == srtf_pkg::KIND_RESTART))
                begin
                    state_next = srtf_pkg::ST_RESTART;
                end
            end
            srtf_pkg::ST_RESTART:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = srtf_pkg::ST_IDLE;
                end
            end
            srtf_pkg::ST_SCAN:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = srtf_pkg::ST_RUN;
                end
            end
            srtf_pkg::ST_RUN:  state_next = srtf_pkg::ST_TAT;
            srtf_pkg::ST_TAT:  state_next = srtf_pkg::ST_WAIT;
            srtf_pkg::ST_WAIT: state_next = srtf_pkg::ST_OUT;
            srtf_pkg::ST_OUT:
            begin
                if (!rpt_valid_reg || !rpt_stall)
                begin
                    state_next = srtf_pkg::ST_IDLE;
                end
            end
            default: state_next = srtf_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        time_next       = time_reg;
        done_cnt_next   = done_cnt_reg;
        last_valid_next = last_valid_reg;
        last_slot_next  = last_slot_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = idx_reg[IDX_W-1:0];
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_rem_next   = best_rem_reg;
        best_next       = best_reg;
        res_next        = res_reg;
        rpt_next        = rpt_reg;
        rpt_valid_next  = rpt_valid_reg && rpt_stall;

        unique case (state_reg)
            srtf_pkg::ST_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                if (accept && (cmd.kind == srtf_pkg::KIND_RESTART))
                begin
                    time_next       = 16'd0;
                    done_cnt_next   = '0;
                    last_valid_next = 1'b0;
                    last_slot_next  = '0;
                end
            end
            srtf_pkg::ST_RESTART,
            srtf_pkg::ST_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                // compare unit on the entry read last cycle
                if ((state_reg == srtf_pkg::ST_SCAN) && pend_reg
                    && (rd_entry.arrival <= time_reg) && (rd_rem != 12'd0)
                    && (!found_reg || (rd_rem < best_rem_reg)))
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_rem_next = rd_rem;
                    best_next     = rd_entry;
                end
            end
            srtf_pkg::ST_RUN:
            begin
                time_next = time_inc;
                res_next  = '0;
                res_next.time_now = time_reg;
                if (found_reg)
                begin
                    res_next.running_valid = 1'b1;
                    res_next.running_pid   = best_reg.id;
                    res_next.new_segment   = !last_valid_reg || (last_slot_reg != best_idx_reg);
                    last_valid_next        = 1'b1;
                    last_slot_next         = best_idx_reg;
                    if (best_rem_reg == 12'd1)
                    begin
                        res_next.finished    = 1'b1;
                        res_next.finish_time = time_inc;
                        done_cnt_next        = done_cnt_reg + CNT_W'(1);
                    end
                end
            end
            srtf_pkg::ST_TAT:
            begin
                res_next.all_done = (done_cnt_reg >= active_n);
                if (res_reg.finished && (res_reg.finish_time >= best_reg.arrival))
                begin
                    res_next.turnaround = res_reg.finish_time - best_reg.arrival;
                end
            end
            srtf_pkg::ST_WAIT:
            begin
                if (res_reg.finished && (res_reg.turnaround >= 16'(best_reg.burst)))
                begin
                    res_next.waiting = res_reg.turnaround - 16'(best_reg.burst);
                end
            end
            srtf_pkg::ST_OUT:
            begin
                if (!rpt_valid_reg || !rpt_stall)
                begin
                    rpt_next       = res_reg;
                    rpt_valid_next = 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srtf_pkg::ST_IDLE;
            pc_reg         <= 5'd1;
            time_reg       <= 16'd0;
            done_cnt_reg   <= '0;
            last_valid_reg <= 1'b0;
            last_slot_reg  <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            rpt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                pc_reg <= cfg_wr_data;
            end
            time_reg       <= time_next;
            done_cnt_reg   <= done_cnt_next;
            last_valid_reg <= last_valid_next;
            last_slot_reg  <= last_slot_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            rpt_valid_reg  <= rpt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        rpt_reg      <= rpt_next;
    end

endmodule
